### sv/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg: shared types and constants for the answer-to-reset parser
// Byte class codes, parse phases, convention codes and the state and result
// records passed between the classifier and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package atrp_pkg;

	typedef enum logic [3:0] {
		CLS_TS      = 4'd0,
		CLS_T0      = 4'd1,
		CLS_TA      = 4'd2,
		CLS_TB      = 4'd3,
		CLS_TC      = 4'd4,
		CLS_TD      = 4'd5,
		CLS_HIST    = 4'd6,
		CLS_TCK     = 4'd7,
		CLS_SURPLUS = 4'd8
	} atrp_class_t;

	typedef enum logic [2:0] {
		PH_TS    = 3'd0,
		PH_T0    = 3'd1,
		PH_IFACE = 3'd2,
		PH_HIST  = 3'd3,
		PH_TCK   = 3'd4,
		PH_DONE  = 3'd5
	} atrp_phase_t;

	localparam logic [1:0] CONV_DIRECT  = 2'd0;
	localparam logic [1:0] CONV_INVERSE = 2'd1;
	localparam logic [1:0] CONV_UNKNOWN = 2'd2;

	localparam logic [7:0] TS_DIRECT  = 8'h3B;
	localparam logic [7:0] TS_INVERSE = 8'h3F;

	localparam logic [3:0] GROUP_MAX = 4'd15;
	localparam logic [3:0] GROUP_CRC = 4'd3;

	// Bit positions of the announced interface bytes in the pending mask.
	localparam int unsigned PEND_TA = 0;
	localparam int unsigned PEND_TB = 1;
	localparam int unsigned PEND_TC = 2;

	typedef struct packed {
		atrp_phase_t phase;
		logic [3:0]  pending;
		logic [3:0]  group;
		logic [3:0]  hist_left;
	} atrp_state_t;

	typedef struct packed {
		atrp_class_t byte_class;
		logic [3:0]  group_index;
		logic [1:0]  convention;
		logic [3:0]  low_nibble;
		logic        uses_crc;
		logic [7:0]  byte_echo;
	} atrp_result_t;

endpackage

`default_nettype wire

### sv/atrp_classify.sv
// ----------------------------------------------------------------------------
// atrp_classify: byte classifier and parse state update
// Names one answer-to-reset byte from the current parse state and computes
// the state that follows it. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_classify (
	input  wire logic [7:0]           data_byte,
	input  wire logic                 frame_start,
	input  wire atrp_pkg::atrp_state_t  cur,
	output atrp_pkg::atrp_state_t       nxt,
	output atrp_pkg::atrp_result_t      res
);
	import atrp_pkg::*;

	logic [3:0]  grp_inc;
	logic [3:0]  hist_dec;
	logic [3:0]  t0_hist;
	atrp_phase_t t0_phase;
	atrp_phase_t td_phase;
	atrp_phase_t after_iface;

	assign grp_inc  = (cur.group == GROUP_MAX) ? cur.group : cur.group + 4'd1;
	assign hist_dec = (cur.hist_left != 4'd0) ? cur.hist_left - 4'd1 : cur.hist_left;
	assign t0_hist  = data_byte[3:0];

	// Phase that follows a T0 or TD byte, which opens a new group.
	assign t0_phase = (data_byte[7:4] != 4'd0) ? PH_IFACE :
	                  (t0_hist != 4'd0)        ? PH_HIST  : PH_TCK;
	assign td_phase = (data_byte[7:4] != 4'd0)   ? PH_IFACE :
	                  (cur.hist_left != 4'd0)    ? PH_HIST  : PH_TCK;
	assign after_iface = (cur.hist_left != 4'd0) ? PH_HIST : PH_TCK;

	always_comb begin
		nxt             = cur;
		res.byte_class  = CLS_SURPLUS;
		res.group_index = 4'd0;
		res.convention  = CONV_DIRECT;
		res.low_nibble  = 4'd0;
		res.uses_crc    = 1'b0;
		res.byte_echo   = data_byte;

		if (frame_start) begin
			res.byte_class = CLS_TS;
			if (data_byte == TS_DIRECT) begin
				res.convention = CONV_DIRECT;
			end else if (data_byte == TS_INVERSE) begin
				res.convention = CONV_INVERSE;
			end else begin
				res.convention = CONV_UNKNOWN;
			end
			nxt.phase     = PH_T0;
			nxt.pending   = 4'd0;
			nxt.group     = 4'd0;
			nxt.hist_left = 4'd0;
		end else begin
			case (cur.phase)
				PH_T0: begin
					res.byte_class = CLS_T0;
					res.low_nibble = data_byte[3:0];
					nxt.hist_left  = t0_hist;
					nxt.pending    = data_byte[7:4];
					nxt.group      = grp_inc;
					nxt.phase      = t0_phase;
				end
				PH_IFACE: begin
					res.group_index = cur.group;
					if (cur.pending[PEND_TA]) begin
						res.byte_class = CLS_TA;
						nxt.pending    = cur.pending & 4'b1110;
						if ((cur.pending & 4'b1110) == 4'd0) begin
							nxt.phase = after_iface;
						end
					end else if (cur.pending[PEND_TB]) begin
						res.byte_class = CLS_TB;
						nxt.pending    = cur.pending & 4'b1100;
						if ((cur.pending & 4'b1100) == 4'd0) begin
							nxt.phase = after_iface;
						end
					end else if (cur.pending[PEND_TC]) begin
						res.byte_class = CLS_TC;
						res.uses_crc   = (cur.group == GROUP_CRC) ? data_byte[0] : 1'b0;
						nxt.pending    = cur.pending & 4'b1000;
						if ((cur.pending & 4'b1000) == 4'd0) begin
							nxt.phase = after_iface;
						end
					end else begin
						res.byte_class = CLS_TD;
						res.low_nibble = data_byte[3:0];
						nxt.pending    = data_byte[7:4];
						nxt.group      = grp_inc;
						nxt.phase      = td_phase;
					end
				end
				PH_HIST: begin
					res.byte_class = CLS_HIST;
					nxt.hist_left  = hist_dec;
					if (hist_dec == 4'd0) begin
						nxt.phase = PH_TCK;
					end
				end
				PH_TCK: begin
					res.byte_class = CLS_TCK;
					nxt.phase      = PH_DONE;
				end
				default: begin
					// No answer open, answer complete, or an unused phase code.
					nxt = cur;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/smart_card_atr_parser_core.sv
// ----------------------------------------------------------------------------
// smart_card_atr_parser_core: answer-to-reset byte parser
// Classifies each answer-to-reset byte and reports its group, convention,
// protocol nibble and error detection kind, with the byte echoed.
//
//  Channel   Dir  Width   Contents
//  s_axis    in   8 + 1   tdata: data_byte; tuser: frame_start
//  m_axis    out  24 + 4  tdata: result fields; tuser: byte_class
//
// One byte per cycle sustained while m_axis takes each beat; a beat is offered
// on m_axis once it has passed the input register and then the result register.
// The parse state advances as a byte moves from the input register to the
// result register, so a stall on m_axis holds the state, and holds s_axis as
// soon as the input register is also full.
// Reset clears the valid flags and puts the parser in the wait-for-TS state.
// ----------------------------------------------------------------------------
`default_nettype none

module smart_card_atr_parser_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tuser,  // [0] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [3:0] group_index, [5:4] convention,
	                                        // [9:6] low_nibble, [10] uses_crc,
	                                        // [18:11] byte_echo, [23:19] zero
	output logic [3:0]       m_axis_tuser   // [3:0] byte_class
);
	import atrp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         valid_s2;
	atrp_result_t res_s2;
	atrp_state_t  state_q;
	atrp_state_t  state_nxt;
	atrp_result_t res_nxt;
	logic         out_free;
	logic         adv_s1;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	atrp_classify u_classify (
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			valid_s2          <= 1'b0;
			state_q.phase     <= PH_TS;
			state_q.pending   <= 4'd0;
			state_q.group     <= 4'd0;
			state_q.hist_left <= 4'd0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.byte_class;
	assign m_axis_tdata  = {5'd0, res_s2.byte_echo, res_s2.uses_crc, res_s2.low_nibble,
	                        res_s2.convention, res_s2.group_index};

	// A TS byte always restarts the parse at T0.
	a_ts_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && start_s1 |=> state_q.phase == PH_T0)
		else $error("TS byte did not restart the parse");

	// Interface phase always has at least one announced byte outstanding.
	a_iface_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_IFACE |-> state_q.pending != 4'd0)
		else $error("interface phase with nothing pending");

	// Historical phase always has at least one historical byte to come.
	a_hist_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_HIST |-> state_q.hist_left != 4'd0)
		else $error("historical phase with zero count");

	// Only interface bytes carry a group number.
	a_group_iface_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !(res_s2.byte_class == CLS_TA || res_s2.byte_class == CLS_TB ||
		res_s2.byte_class == CLS_TC || res_s2.byte_class == CLS_TD)
		|-> res_s2.group_index == 4'd0)
		else $error("group number on a non-interface byte");

	// The state holds whenever no byte moves into the result register.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("parse state changed without a byte");

endmodule

`default_nettype wire
